[rtl/core/ntc_pkg.sv]
package ntc_pkg;

   // register map
   localparam logic [2:0] CSR_FULL_SCALE   = 3'd0;
   localparam logic [2:0] CSR_SERIES_RES   = 3'd1;
   localparam logic [2:0] CSR_NOMINAL_RES  = 3'd2;
   localparam logic [2:0] CSR_BETA         = 3'd3;
   localparam logic [2:0] CSR_NOMINAL_TEMP = 3'd4;

   localparam int CSR_DATA_W = 20;
   localparam int RES_W      = 20;

   // register limits applied on use
   localparam logic [15:0] FS_MIN    = 16'd255;
   localparam logic [19:0] RES_MIN   = 20'd100;
   localparam logic [19:0] RES_MAX   = 20'd1000000;
   localparam logic [13:0] BETA_MIN  = 14'd1000;
   localparam logic [13:0] BETA_MAX  = 14'd10000;
   localparam logic [15:0] T0_MIN    = 16'd20000;
   localparam logic [15:0] T0_MAX    = 16'd40000;

   // ln(2) in q24
   localparam logic [23:0] LN2_Q24 = 24'd11629080;

   localparam logic [15:0] ZERO_C_CK = 16'd27315;
   localparam logic [15:0] HOT_CK    = 16'd42315;
   localparam logic [15:0] COLD_CK   = 16'd23315;

   localparam logic signed [14:0] HOT_CENTI  = 15'sd15000;
   localparam logic signed [14:0] COLD_CENTI = -15'sd4000;

   typedef enum logic [1:0] {
      ST_VALID   = 2'd0,
      ST_INVALID = 2'd1,
      ST_HOT     = 2'd2,
      ST_COLD    = 2'd3
   } status_type;

endpackage

[rtl/core/ntc_div.sv]
module ntc_div #(
   parameter int DVD_W = 58,
   parameter int DSR_W = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DSR_W-1:0] rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DSR_W-1:0] dsr_ff;
   logic [DSR_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            // one quotient bit per cycle, restoring
            rem_ff <= fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
            quo_ff <= {quo_ff[DVD_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/ntc_thermistor_temperature.sv]
// NTC thermometer: each accepted ADC code enters a ring of the last AVERAGE_DEPTH
// samples, and the ring sum gives the divider resistance, which goes through the
// beta equation to a temperature in 0.01 C with a status code. One transaction
// in gives one result out. The log2 unit normalizes one bit per cycle and
// squares once per fraction bit on the shared 32x32 multiplier, and the divider
// retires one quotient bit per cycle. After reset the sample ring is zeroed
// before the first transaction is taken; register writes are taken at any time.
module ntc_thermistor_temperature import ntc_pkg::*; #(
   parameter int AVERAGE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [11:0]           req_adc_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [14:0]    rsp_temperature_centi_c,
   output logic [1:0]            rsp_status,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW    = $clog2(AVERAGE_DEPTH);
   localparam int SUM_W = $clog2(4095 * AVERAGE_DEPTH + 1);
   localparam int TOP_W = $clog2(65535 * AVERAGE_DEPTH + 1);
   localparam int A_W   = RES_W + SUM_W;
   localparam int B_W   = RES_W + TOP_W;
   localparam int X_W   = (A_W > B_W) ? A_W : B_W;
   localparam int K_W   = $clog2(X_W);
   localparam int DVD_W = 58;
   localparam int DEN_W = 43;

   localparam logic [SUM_W-1:0] SUM_LOW  = SUM_W'(AVERAGE_DEPTH);
   localparam logic [SUM_W-1:0] SUM_HIGH = SUM_W'(4094 * AVERAGE_DEPTH);
   localparam logic [PW-1:0]    POS_LAST = PW'(AVERAGE_DEPTH - 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_SUM, S_CHECK, S_MUL_A, S_MUL_B, S_RANGE, S_NORM, S_SQUARE,
      S_LN_LO, S_LN_HI, S_MUL_LT, S_MUL_TB, S_DEN, S_DIV_GO, S_DIVIDE, S_FINAL, S_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] cfg_fs_ff;
   logic [19:0] cfg_rs_ff;
   logic [19:0] cfg_r0_ff;
   logic [13:0] cfg_beta_ff;
   logic [15:0] cfg_t0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_fs_ff   <= 16'd4095;
         cfg_rs_ff   <= 20'd10000;
         cfg_r0_ff   <= 20'd10000;
         cfg_beta_ff <= 14'd3950;
         cfg_t0_ff   <= 16'd29815;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FULL_SCALE:   cfg_fs_ff   <= csr_wdata[15:0];
            CSR_SERIES_RES:   cfg_rs_ff   <= csr_wdata[19:0];
            CSR_NOMINAL_RES:  cfg_r0_ff   <= csr_wdata[19:0];
            CSR_BETA:         cfg_beta_ff <= csr_wdata[13:0];
            CSR_NOMINAL_TEMP: cfg_t0_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [15:0] fs_s;
   logic [19:0] rs_s;
   logic [19:0] r0_s;
   logic [13:0] beta_s;
   logic [15:0] t0_s;

   assign fs_s   = (cfg_fs_ff < FS_MIN) ? FS_MIN : cfg_fs_ff;
   assign rs_s   = (cfg_rs_ff < RES_MIN) ? RES_MIN : ((cfg_rs_ff > RES_MAX) ? RES_MAX : cfg_rs_ff);
   assign r0_s   = (cfg_r0_ff < RES_MIN) ? RES_MIN : ((cfg_r0_ff > RES_MAX) ? RES_MAX : cfg_r0_ff);
   assign beta_s = (cfg_beta_ff < BETA_MIN) ? BETA_MIN :
                   ((cfg_beta_ff > BETA_MAX) ? BETA_MAX : cfg_beta_ff);
   assign t0_s   = (cfg_t0_ff < T0_MIN) ? T0_MIN : ((cfg_t0_ff > T0_MAX) ? T0_MAX : cfg_t0_ff);

   // sample ring
   logic [11:0]      ring_mem [AVERAGE_DEPTH];
   logic [11:0]      rd_ff;
   logic [11:0]      sample_ff;
   logic [PW-1:0]    pos_ff;
   logic [PW-1:0]    clr_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             req_acc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         ring_mem[clr_ff] <= '0;
      end else if (req_acc) begin
         ring_mem[pos_ff] <= req_adc_sample;
      end
      // old entry of the slot being replaced
      rd_ff <= ring_mem[pos_ff];
   end

   // datapath registers
   logic [TOP_W-1:0] dpos_ff;
   logic [A_W-1:0]   a_ff;
   logic [B_W-1:0]   b_ff;
   logic [X_W-1:0]   xs_ff;
   logic [K_W-1:0]   k_ff;
   logic             log_sel_ff;
   logic [31:0]      m_ff;
   logic [35:0]      res_ff;
   logic [4:0]       bit_ff;
   logic [35:0]      la_ff;
   logic [35:0]      lb_ff;
   logic [41:0]      plo_ff;
   logic [25:0]      lmag_ff;
   logic [41:0]      pl_ff;
   logic [29:0]      tb_ff;
   logic [DEN_W-1:0] den_ff;
   logic signed [14:0] res_temp_ff;
   status_type       res_stat_ff;
   logic             rsp_valid_ff;
   logic signed [14:0] rsp_temp_ff;
   status_type       rsp_stat_ff;

   // shared multiplier
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] mul_p;

   logic [35:0] mag;
   logic        neg;

   assign neg = (la_ff < lb_ff);
   assign mag = neg ? (lb_ff - la_ff) : (la_ff - lb_ff);

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         S_MUL_A:  begin mul_x = 32'(rs_s);        mul_y = 32'(sum_ff);  end
         S_MUL_B:  begin mul_x = 32'(r0_s);        mul_y = 32'(dpos_ff); end
         S_SQUARE: begin mul_x = m_ff;             mul_y = m_ff;         end
         S_LN_LO:  begin mul_x = 32'(mag[17:0]);   mul_y = 32'(LN2_Q24); end
         S_LN_HI:  begin mul_x = 32'(mag[35:18]);  mul_y = 32'(LN2_Q24); end
         S_MUL_LT: begin mul_x = 32'(lmag_ff);     mul_y = 32'(t0_s);    end
         S_MUL_TB: begin mul_x = 32'(t0_s);        mul_y = 32'(beta_s);  end
         default: ;
      endcase
   end

   assign mul_p = mul_x * mul_y;

   logic [TOP_W-1:0] top_val;
   logic [B_W-1:0]   dp200;
   logic [B_W-1:0]   dp50k;
   logic [32:0]      sq_t;
   logic [35:0]      res_nxt;
   logic [59:0]      ln_full;
   logic [39:0]      bterm;
   logic [DVD_W-1:0] dividend;
   logic             div_done;
   logic [DVD_W-1:0] div_quo;
   logic             emit_go;

   assign top_val  = TOP_W'(32'(fs_s) * AVERAGE_DEPTH);
   assign dp200    = B_W'(dpos_ff) * B_W'(200);
   assign dp50k    = B_W'(dpos_ff) * B_W'(50000);
   assign sq_t     = mul_p[63:31];
   assign res_nxt  = res_ff | (sq_t[32] ? (36'd1 << bit_ff) : 36'd0);
   assign ln_full  = {mul_p[41:0], 18'd0} + 60'(plo_ff);
   assign bterm    = {20'(32'(beta_s) * 100), 20'd0};
   assign dividend = DVD_W'({37'(tb_ff) * 37'd100, 20'd0}) + DVD_W'(den_ff >> 1);
   assign emit_go  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   ntc_div #(
      .DVD_W (DVD_W),
      .DSR_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .dividend (dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == POS_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  sample_ff <= req_adc_sample;
                  pos_ff    <= (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
                  state_ff  <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff   <= sum_ff - SUM_W'(rd_ff) + SUM_W'(sample_ff);
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (sum_ff <= SUM_LOW || sum_ff >= SUM_HIGH) begin
                  res_temp_ff <= '0;
                  res_stat_ff <= ST_INVALID;
                  state_ff    <= S_EMIT;
               end else if (TOP_W'(sum_ff) == top_val) begin
                  // infinite resistance
                  res_temp_ff <= COLD_CENTI;
                  res_stat_ff <= ST_COLD;
                  state_ff    <= S_EMIT;
               end else if (TOP_W'(sum_ff) > top_val) begin
                  res_temp_ff <= HOT_CENTI;
                  res_stat_ff <= ST_HOT;
                  state_ff    <= S_EMIT;
               end else begin
                  dpos_ff  <= top_val - TOP_W'(sum_ff);
                  state_ff <= S_MUL_A;
               end
            end
            S_MUL_A: begin
               a_ff     <= mul_p[A_W-1:0];
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               b_ff     <= mul_p[B_W-1:0];
               state_ff <= S_RANGE;
            end
            S_RANGE: begin
               if (B_W'(a_ff) <= dp200) begin
                  res_temp_ff <= HOT_CENTI;
                  res_stat_ff <= ST_HOT;
                  state_ff    <= S_EMIT;
               end else if (B_W'(a_ff) >= dp50k) begin
                  res_temp_ff <= COLD_CENTI;
                  res_stat_ff <= ST_COLD;
                  state_ff    <= S_EMIT;
               end else begin
                  xs_ff      <= X_W'(a_ff);
                  k_ff       <= '0;
                  log_sel_ff <= 1'b0;
                  state_ff   <= S_NORM;
               end
            end
            S_NORM: begin
               if (xs_ff[X_W-1]) begin
                  m_ff     <= xs_ff[X_W-1 -: 32];
                  res_ff   <= {6'(X_W - 1 - int'(k_ff)), 30'd0};
                  bit_ff   <= 5'd29;
                  state_ff <= S_SQUARE;
               end else begin
                  xs_ff <= xs_ff << 1;
                  k_ff  <= k_ff + 1'b1;
               end
            end
            S_SQUARE: begin
               // one fraction bit per squaring of the mantissa
               m_ff   <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
               res_ff <= res_nxt;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 5'd0) begin
                  if (!log_sel_ff) begin
                     la_ff      <= res_nxt;
                     xs_ff      <= X_W'(b_ff);
                     k_ff       <= '0;
                     log_sel_ff <= 1'b1;
                     state_ff   <= S_NORM;
                  end else begin
                     lb_ff    <= res_nxt;
                     state_ff <= S_LN_LO;
                  end
               end
            end
            S_LN_LO: begin
               plo_ff   <= mul_p[41:0];
               state_ff <= S_LN_HI;
            end
            S_LN_HI: begin
               lmag_ff  <= ln_full[59:34];
               state_ff <= S_MUL_LT;
            end
            S_MUL_LT: begin
               pl_ff    <= mul_p[41:0];
               state_ff <= S_MUL_TB;
            end
            S_MUL_TB: begin
               tb_ff    <= mul_p[29:0];
               state_ff <= S_DEN;
            end
            S_DEN: begin
               if (neg && (DEN_W'(pl_ff) >= DEN_W'(bterm))) begin
                  res_temp_ff <= HOT_CENTI;
                  res_stat_ff <= ST_HOT;
                  state_ff    <= S_EMIT;
               end else begin
                  den_ff   <= neg ? DEN_W'(bterm) - DEN_W'(pl_ff)
                                  : DEN_W'(bterm) + DEN_W'(pl_ff);
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               if (div_done) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (div_quo > DVD_W'(HOT_CK)) begin
                  res_temp_ff <= HOT_CENTI;
                  res_stat_ff <= ST_HOT;
               end else if (div_quo < DVD_W'(COLD_CK)) begin
                  res_temp_ff <= COLD_CENTI;
                  res_stat_ff <= ST_COLD;
               end else begin
                  res_temp_ff <= 15'(div_quo[15:0] - ZERO_C_CK);
                  res_stat_ff <= ST_VALID;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_temp_ff  <= res_temp_ff;
                  rsp_stat_ff  <= res_stat_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_temperature_centi_c = rsp_temp_ff;
   assign rsp_status              = rsp_stat_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INVALID |-> rsp_temperature_centi_c == 15'sd0)
      else $error("invalid reading carries nonzero temperature");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_VALID |->
         rsp_temperature_centi_c >= COLD_CENTI && rsp_temperature_centi_c <= HOT_CENTI)
      else $error("valid temperature out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction accepted while previous one in progress");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall && !rsp_valid)
      else $error("ring clear overlapped traffic");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ntc_pkg::*;

   localparam int DEPTH       = 16;
   localparam int SETTLE      = 260;
   localparam int WATCH_LIMIT = 20000;
   localparam int HOLD_CYCLES = 900;
   localparam int NUM_PHASES  = 7;
   localparam int PHASE_ITEMS = 185;

   typedef struct packed {
      logic signed [14:0] temp;
      status_type         st;
   } reading_type;

   typedef struct {
      logic [11:0] sample;
      bit          typed;
      reading_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [11:0]           req_adc_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [14:0]    rsp_temperature_centi_c;
   logic [1:0]            rsp_status;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ntc_thermistor_temperature #(.AVERAGE_DEPTH(DEPTH)) dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [15:0] full_scale_reg;
   logic [19:0] series_reg;
   logic [19:0] r_nominal_reg;
   logic [13:0] beta_reg;
   logic [15:0] t_nominal_reg;
   logic [11:0] ring [DEPTH];
   int unsigned ring_pos;
   int unsigned ring_sum;

   reading_type pending_readings[$];
   int       mismatches = 0;
   int       samples_sent = 0;
   int       readings_seen = 0;
   int       status_seen[4] = '{0, 0, 0, 0};
   bit       idling_on = 1'b1;
   int       hold_requests = 0;
   int       hold_served = 0;
   int       watch_count = 0;

   logic [11:0] directed_vals[7] = '{12'd2048, 12'd1, 12'd2, 12'd4094, 12'd1024, 12'd80,
                                     12'd3410};

   function automatic logic [63:0] log2_fixed(logic [63:0] x);
      int          top;
      logic [63:0] m;
      logic [63:0] r;
      top = 63;
      while (top > 0 && !x[top]) top--;
      m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
      r = 64'(top) << 30;
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic reading_type mk(logic signed [14:0] t, status_type s);
      reading_type r;
      r.temp = t;
      r.st   = s;
      return r;
   endfunction

   function automatic reading_type thermistor_reading(logic [11:0] s);
      logic [63:0] fs, rs, r0, beta, t0, sum, top, a, b, dpos, la, lb, dmag, lmag, num, tck;
      longint      den, l20;
      bit          neg;
      fs   = clip(full_scale_reg, 255, 65535);
      rs   = clip(series_reg, 100, 1000000);
      r0   = clip(r_nominal_reg, 100, 1000000);
      beta = clip(beta_reg, 1000, 10000);
      t0   = clip(t_nominal_reg, 20000, 40000);
      ring_sum = ring_sum - ring[ring_pos] + s;
      ring[ring_pos] = s;
      ring_pos = (ring_pos + 1) % DEPTH;
      sum = ring_sum;
      if (sum <= DEPTH || sum >= 4094 * DEPTH) return mk(0, ST_INVALID);
      top = fs * DEPTH;
      if (sum == top) return mk(COLD_CENTI, ST_COLD);
      if (sum > top) return mk(HOT_CENTI, ST_HOT);
      a    = rs * sum;
      dpos = top - sum;
      if (a <= 200 * dpos) return mk(HOT_CENTI, ST_HOT);
      if (a >= 50000 * dpos) return mk(COLD_CENTI, ST_COLD);
      b    = r0 * dpos;
      la   = log2_fixed(a);
      lb   = log2_fixed(b);
      neg  = la < lb;
      dmag = neg ? lb - la : la - lb;
      lmag = (dmag * 64'(LN2_Q24)) >> 34;
      l20  = neg ? -longint'(lmag) : longint'(lmag);
      den  = longint'((100 * beta) << 20) + l20 * longint'(t0);
      if (den <= 0) return mk(HOT_CENTI, ST_HOT);
      num = (100 * t0 * beta) << 20;
      tck = (num + 64'(den) / 2) / 64'(den);
      if (tck > 64'(HOT_CK)) return mk(HOT_CENTI, ST_HOT);
      if (tck < 64'(COLD_CK)) return mk(COLD_CENTI, ST_COLD);
      return mk(15'(longint'(tck) - longint'(ZERO_C_CK)), ST_VALID);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FULL_SCALE:   full_scale_reg = val[15:0];
         CSR_SERIES_RES:   series_reg     = val[19:0];
         CSR_NOMINAL_RES:  r_nominal_reg  = val[19:0];
         CSR_BETA:         beta_reg       = val[13:0];
         CSR_NOMINAL_TEMP: t_nominal_reg  = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(logic [11:0] s, bit typed, reading_type want);
      int gap;
      reading_type r;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (req_stall);
      r = thermistor_reading(s);
      pending_readings.push_back(typed ? want : r);
      samples_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // result side: checking and stall bursts
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      reading_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            status_seen[rsp_status]++;
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: temp %0d status %0d",
                           rsp_temperature_centi_c, rsp_status);
            end else begin
               e = pending_readings.pop_front();
               if (rsp_temperature_centi_c !== e.temp || rsp_status !== e.st) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                              e.temp, e.st, rsp_temperature_centi_c, rsp_status);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watch_count = 0;
      else watch_count++;
      if (watch_count >= WATCH_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_readings.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   directed_row_type directed[$];

   initial begin
      logic [CSR_DATA_W-1:0] phase_regs [NUM_PHASES][5];
      logic [11:0] level;
      int          run_len;
      int          limit;
      reading_type none;
      directed_row_type row;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_adc_sample <= '0;
      csr_write      <= 1'b0;
      csr_index      <= CSR_FULL_SCALE;
      csr_wdata      <= '0;
      full_scale_reg = 16'd4095;
      series_reg     = 20'd10000;
      r_nominal_reg  = 20'd10000;
      beta_reg       = 14'd3950;
      t_nominal_reg  = 16'd29815;
      foreach (ring[i]) ring[i] = '0;
      ring_pos = 0;
      ring_sum = 0;
      none = mk(0, ST_VALID);

      // low extremes, high extremes, out of range, typical, odd mix, random, typical
      phase_regs[0] = '{20'd255, 20'd100, 20'd100, 20'd1000, 20'd20000};
      phase_regs[1] = '{20'd65535, 20'd1000000, 20'd1000000, 20'd10000, 20'd40000};
      phase_regs[2] = '{20'd0, 20'hFFFFF, 20'd0, 20'h3FFF, 20'hFFFF};
      phase_regs[3] = '{20'd4095, 20'd10000, 20'd10000, 20'd3950, 20'd29815};
      phase_regs[4] = '{20'd1023, 20'd4700, 20'd100000, 20'd3435, 20'd29815};
      phase_regs[5] = '{20'($urandom_range(255, 4095)), 20'($urandom_range(100, 1000000)),
                        20'($urandom_range(100, 1000000)), 20'($urandom_range(1000, 10000)),
                        20'($urandom_range(20000, 40000))};
      phase_regs[6] = '{20'd4095, 20'd10000, 20'd10000, 20'd3950, 20'd29815};

      // directed: empty ring, a full-scale run, then a mix of mid, low and high codes
      row = '{12'd0, 1'b1, mk(0, ST_INVALID)};
      directed.push_back(row);
      for (int i = 0; i < DEPTH; i++) begin
         row = '{12'd4095, i == DEPTH - 1, mk(0, ST_INVALID)};
         directed.push_back(row);
      end
      foreach (directed_vals[i]) begin
         row = '{directed_vals[i], 1'b0, none};
         directed.push_back(row);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_sample(directed[i].sample, directed[i].typed, directed[i].want);

      for (int p = -1; p < NUM_PHASES; p++) begin
         if (p >= 0) begin
            drain();
            for (int r = 0; r < 5; r++) write_reg(3'(r), phase_regs[p][r]);
            csr_write <= 1'b0;
            @(posedge clock);
         end
         if (p == NUM_PHASES - 1) idling_on = 1'b0;
         if (p == 3) hold_requests++;
         limit = (full_scale_reg < 16'd4095 && full_scale_reg >= 16'd255) ? full_scale_reg : 4095;
         run_len = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (run_len == 0) begin
               run_len = $urandom_range(16, 48);
               case ($urandom_range(0, 9))
                  0:       level = 12'(limit);
                  1:       level = 12'($urandom_range(0, 40));
                  2:       level = 12'($urandom_range(4055, 4095));
                  default: level = 12'($urandom_range(0, 4095));
               endcase
            end
            run_len--;
            if ($urandom_range(0, 3) == 0)
               send_sample(12'($urandom_range(0, 4095)), 1'b0, none);
            else if (level == 12'(limit) || $urandom_range(0, 1) == 0)
               send_sample(level, 1'b0, none);
            else
               send_sample(12'(int'(level) + $urandom_range(0, 16) - 8), 1'b0, none);
         end
      end

      drain();
      $display("%0d samples across %0d register settings, %0d results checked",
               samples_sent, NUM_PHASES + 1, readings_seen);
      $display("status counts: valid %0d invalid %0d hot %0d cold %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
